>>> rtl/core/bfa_pkg.sv
`default_nettype none

package bfa_pkg;

   // Bitmap geometry: one bit per frame, 1 = used, 0 = free.
   localparam int unsigned ROW_WIDTH   = 64;
   localparam int unsigned ROW_COUNT   = 512;
   localparam int unsigned COL_BITS    = $clog2(ROW_WIDTH);
   localparam int unsigned ROW_BITS    = $clog2(ROW_COUNT);

   // Field widths of the request, response and page count register.
   localparam int unsigned FRAME_BITS  = 15;
   localparam int unsigned COUNT_BITS  = 16;
   localparam int unsigned KIND_BITS   = 2;
   localparam int unsigned STATUS_BITS = 2;

   // The not-full summary is searched in two steps: a group, then a row within it.
   localparam int unsigned GROUP_SIZE  = 64;
   localparam int unsigned GROUP_COUNT = ROW_COUNT / GROUP_SIZE;
   localparam int unsigned GROUP_BITS  = $clog2(GROUP_COUNT);
   localparam int unsigned GSEL_BITS   = $clog2(GROUP_SIZE);

   // Highest frame limit the bitmap and the frame field can hold.
   localparam int unsigned FRAME_SPACE_RAW =
      (ROW_COUNT * ROW_WIDTH < (2 ** FRAME_BITS)) ? ROW_COUNT * ROW_WIDTH : (2 ** FRAME_BITS);
   localparam logic [COUNT_BITS-1:0] FRAME_SPACE = COUNT_BITS'(FRAME_SPACE_RAW);
   localparam logic [COUNT_BITS-1:0] PAGE_COUNT_RESET = COUNT_BITS'(32768);

   localparam logic [ROW_WIDTH-1:0] ROW_ONES = '1;

   // Request kinds.
   typedef enum logic [KIND_BITS-1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_MARK  = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   // Response status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_NONE  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // Result of the summary search: lowest row that still has a free frame.
   typedef struct packed {
      logic                any;
      logic [ROW_BITS-1:0] row;
   } find_type;

   // Summary update after a row has been written back.
   typedef struct packed {
      logic                en;
      logic [ROW_BITS-1:0] row;
      logic                avail;
   } update_type;

   // Index of the lowest set bit of a bitmap row (0 when none is set).
   function automatic logic [COL_BITS-1:0] first_set_col(input logic [ROW_WIDTH-1:0] v);
      logic [COL_BITS-1:0] idx;
      idx = '0;
      for (int i = ROW_WIDTH - 1; i >= 0; i--) begin
         if (v[i]) idx = COL_BITS'(i);
      end
      return idx;
   endfunction

   // Index of the lowest set bit of a summary group word.
   function automatic logic [GSEL_BITS-1:0] first_set_gsel(input logic [GROUP_SIZE-1:0] v);
      logic [GSEL_BITS-1:0] idx;
      idx = '0;
      for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
         if (v[i]) idx = GSEL_BITS'(i);
      end
      return idx;
   endfunction

   // Index of the lowest group that holds a not-full row.
   function automatic logic [GROUP_BITS-1:0] first_set_group(input logic [GROUP_COUNT-1:0] v);
      logic [GROUP_BITS-1:0] idx;
      idx = '0;
      for (int i = GROUP_COUNT - 1; i >= 0; i--) begin
         if (v[i]) idx = GROUP_BITS'(i);
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/bfa_req_if.sv
`default_nettype none

// Request channel: one word per allocate, free, mark or query request.
interface bfa_req_if;
   logic                              valid;
   logic                              ready;
   logic [bfa_pkg::KIND_BITS-1:0]     kind;
   logic [bfa_pkg::FRAME_BITS-1:0]    frame;

   modport source (output valid, output kind, output frame, input ready);
   modport sink   (input valid, input kind, input frame, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bfa_rsp_if.sv
`default_nettype none

// Response channel: one word per request.
interface bfa_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bfa_pkg::FRAME_BITS-1:0]    frame_out;
   logic                              is_free;
   logic [bfa_pkg::STATUS_BITS-1:0]   status;

   modport source (output valid, output frame_out, output is_free, output status, input ready);
   modport sink   (input valid, input frame_out, input is_free, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bfa_summary.sv
`default_nettype none

// Row-not-full summary with a two-step lowest-row search.
// Step one (scan_en) picks the lowest group with a not-full row and registers
// its summary word; step two encodes the row inside that word.
module bfa_summary (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bfa_pkg::update_type upd,
   input  wire logic                scan_en,
   output bfa_pkg::find_type        find
);

   logic [bfa_pkg::ROW_COUNT-1:0]   avail_ff;
   logic [bfa_pkg::ROW_COUNT-1:0]   avail_in;
   logic [bfa_pkg::GROUP_COUNT-1:0] group_any;
   logic [bfa_pkg::GROUP_BITS-1:0]  group_sel;
   logic [bfa_pkg::GROUP_BITS-1:0]  grp_ff;
   logic [bfa_pkg::GROUP_SIZE-1:0]  word_ff;
   logic                            any_ff;

   // A row is marked not-full after a write back that leaves a clear bit.
   always_comb begin
      avail_in = avail_ff;
      if (upd.en) avail_in[upd.row] = upd.avail;
   end

   // Reset leaves every row full, matching the all-used bitmap.
   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= '0;
      end else begin
         avail_ff <= avail_in;
      end
   end

   // One OR per group, then the lowest group that has a not-full row.
   always_comb begin
      for (int g = 0; g < bfa_pkg::GROUP_COUNT; g++) begin
         group_any[g] = |avail_ff[g*bfa_pkg::GROUP_SIZE +: bfa_pkg::GROUP_SIZE];
      end
      group_sel = bfa_pkg::first_set_group(group_any);
   end

   // First search step result.
   always_ff @(posedge clock) begin
      if (scan_en) begin
         grp_ff  <= group_sel;
         word_ff <= avail_ff[group_sel*bfa_pkg::GROUP_SIZE +: bfa_pkg::GROUP_SIZE];
         any_ff  <= |group_any;
      end
   end

   // Second step: row inside the chosen group.
   always_comb begin
      find.any = any_ff;
      find.row = {grp_ff, bfa_pkg::first_set_gsel(word_ff)};
   end

endmodule

`default_nettype wire

>>> rtl/core/bitmap_frame_allocator_top.sv
// Bitmap page frame allocator, first fit.
// Requests arrive as words on req (kind, frame) and each yields exactly one
// response word on rsp (frame_out, is_free, status). Both channels use a
// valid/ready handshake; a word moves at a clock edge with both high.
// The page count register is written through csr_wr_en / csr_wr_data; the user
// must write it only while the block is idle, as the block does not enforce it.
// One request is handled at a time. Allocate passes summary group pick, row
// pick with bitmap read, then bit pick with write back, which loads the
// response register; free, mark and query pass bitmap read, then modify and
// write back. A new request is taken in the cycle after the previous one
// finished, so requests do not overlap; the single read-modify-write of one
// bitmap row per request sets this limit.
// The response sits in an output register; while the receiver stalls, the
// next request is still accepted and worked on, and it waits at its final
// step until the pending response has been taken.
// After reset the bitmap memory is swept to all used, one row per cycle over
// all 512 rows; no request is accepted during the sweep. Page count resets
// to 32768.
`default_nettype none

module bitmap_frame_allocator_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [bfa_pkg::COUNT_BITS-1:0]   csr_wr_data,
   bfa_req_if.sink                               req,
   bfa_rsp_if.source                             rsp
);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_PICK   = 6'b001000,
      ST_LOOKUP = 6'b010000,
      ST_EXEC   = 6'b100000
   } state_type;

   state_type                         state_ff, state_in;
   logic [bfa_pkg::ROW_BITS-1:0]      clr_ff, clr_in;
   logic [bfa_pkg::COUNT_BITS-1:0]    page_count_ff;
   logic [bfa_pkg::KIND_BITS-1:0]     kind_ff;
   logic [bfa_pkg::FRAME_BITS-1:0]    frame_ff;
   logic [bfa_pkg::ROW_BITS-1:0]      row_ff;
   logic                              any_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bfa_pkg::FRAME_BITS-1:0]    rsp_frame_ff;
   logic                              rsp_free_ff;
   logic [bfa_pkg::STATUS_BITS-1:0]   rsp_status_ff;

   logic [bfa_pkg::ROW_WIDTH-1:0]     mem [bfa_pkg::ROW_COUNT];
   logic [bfa_pkg::ROW_WIDTH-1:0]     rd_data_ff;
   logic                              rd_en;
   logic [bfa_pkg::ROW_BITS-1:0]      rd_addr;
   logic                              wr_en;
   logic [bfa_pkg::ROW_BITS-1:0]      wr_addr;
   logic [bfa_pkg::ROW_WIDTH-1:0]     wr_data;

   bfa_pkg::update_type               upd;
   bfa_pkg::find_type                 find;

   logic                              accept;
   logic                              exec_go;
   logic [bfa_pkg::COUNT_BITS-1:0]    limit;
   logic                              frame_ok;
   logic [bfa_pkg::ROW_BITS-1:0]      frame_row;
   logic [bfa_pkg::COL_BITS-1:0]      frame_col;
   logic [bfa_pkg::ROW_WIDTH-1:0]     frame_bit;
   logic [bfa_pkg::ROW_WIDTH-1:0]     free_bits;
   logic [bfa_pkg::COL_BITS-1:0]      alloc_col;
   logic [bfa_pkg::FRAME_BITS-1:0]    pick_frame;
   logic                              alloc_ok;
   logic                              frame_bad;
   logic [bfa_pkg::ROW_WIDTH-1:0]     new_row;
   logic [bfa_pkg::FRAME_BITS-1:0]    res_frame;
   logic                              res_free;
   logic [bfa_pkg::STATUS_BITS-1:0]   res_status;

   // Handshake qualifiers.
   assign accept  = req.valid && req.ready;
   assign exec_go = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp.ready);

   assign req.ready = (state_ff == ST_IDLE);

   // Frame limit: page count, capped by the bitmap size.
   assign limit     = (page_count_ff > bfa_pkg::FRAME_SPACE) ? bfa_pkg::FRAME_SPACE
                                                             : page_count_ff;
   assign frame_ok  = {1'b0, frame_ff} < limit;
   assign frame_row = frame_ff[bfa_pkg::COL_BITS +: bfa_pkg::ROW_BITS];
   assign frame_col = frame_ff[bfa_pkg::COL_BITS-1:0];
   assign frame_bit = bfa_pkg::ROW_WIDTH'(1) << frame_col;
   assign frame_bad = (frame_ff == '0) || !frame_ok;

   // Allocation pick within the row that the summary found.
   assign free_bits   = ~rd_data_ff;
   assign alloc_col   = bfa_pkg::first_set_col(free_bits);
   assign pick_frame  = bfa_pkg::FRAME_BITS'({row_ff, alloc_col});
   assign alloc_ok    = any_ff && (free_bits != '0) && ({1'b0, pick_frame} < limit);

   // Row modification and response fields.
   always_comb begin
      new_row    = rd_data_ff;
      res_frame  = frame_ff;
      res_free   = 1'b0;
      res_status = bfa_pkg::STATUS_OK;
      case (bfa_pkg::kind_type'(kind_ff))
         bfa_pkg::KIND_ALLOC: begin
            if (alloc_ok) begin
               new_row   = rd_data_ff | (bfa_pkg::ROW_WIDTH'(1) << alloc_col);
               res_frame = pick_frame;
            end else begin
               res_frame  = '0;
               res_status = bfa_pkg::STATUS_NONE;
            end
         end
         bfa_pkg::KIND_FREE: begin
            if (frame_bad) res_status = bfa_pkg::STATUS_RANGE;
            else           new_row    = rd_data_ff & ~frame_bit;
         end
         bfa_pkg::KIND_MARK: begin
            if (frame_bad) res_status = bfa_pkg::STATUS_RANGE;
            else           new_row    = rd_data_ff | frame_bit;
         end
         default: begin
            if (!frame_ok) res_status = bfa_pkg::STATUS_RANGE;
            else           res_free   = ~rd_data_ff[frame_col];
         end
      endcase
   end

   // Request sequencer.
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == bfa_pkg::ROW_BITS'(bfa_pkg::ROW_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (bfa_pkg::kind_type'(req.kind) == bfa_pkg::KIND_ALLOC) ? ST_SCAN
                                                                                : ST_LOOKUP;
            end
         end
         ST_SCAN:   state_in = ST_PICK;
         ST_PICK:   state_in = ST_EXEC;
         ST_LOOKUP: state_in = ST_EXEC;
         ST_EXEC: begin
            if (exec_go) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // Page count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= bfa_pkg::PAGE_COUNT_RESET;
      end else if (csr_wr_en) begin
         page_count_ff <= csr_wr_data;
      end
   end

   // Request word and target row.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req.kind;
         frame_ff <= req.frame;
      end
      if (state_ff == ST_PICK) begin
         row_ff <= find.row;
         any_ff <= find.any;
      end else if (state_ff == ST_LOOKUP) begin
         row_ff <= frame_row;
      end
   end

   // Bitmap memory ports: sweep writes during clear, one row read per request.
   assign rd_en   = (state_ff == ST_PICK) || (state_ff == ST_LOOKUP);
   assign rd_addr = (state_ff == ST_PICK) ? find.row : frame_row;
   assign wr_en   = (state_ff == ST_CLEAR) || exec_go;
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff : row_ff;
   assign wr_data = (state_ff == ST_CLEAR) ? bfa_pkg::ROW_ONES : new_row;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // Summary follows every write back.
   always_comb begin
      upd.en    = exec_go;
      upd.row   = row_ff;
      upd.avail = (new_row != bfa_pkg::ROW_ONES);
   end

   bfa_summary u_summary (
      .clock   (clock),
      .reset   (reset),
      .upd     (upd),
      .scan_en (state_ff == ST_SCAN),
      .find    (find)
   );

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go)        rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_frame_ff  <= res_frame;
         rsp_free_ff   <= res_free;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.frame_out = rsp_frame_ff;
   assign rsp.is_free   = rsp_free_ff;
   assign rsp.status    = rsp_status_ff;

`ifndef SYNTHESIS
   // A new response only comes out of the final step.
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> rsp_valid_ff)
      else $error("response not raised after final step");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("response raised outside final step");

   // Frame 0 is never handed out.
   a_no_frame0: assert property (@(posedge clock) disable iff (reset)
      exec_go && (bfa_pkg::kind_type'(kind_ff) == bfa_pkg::KIND_ALLOC) && alloc_ok
      |-> pick_frame != '0)
      else $error("frame 0 allocated");

   // Requests are taken one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready)
      else $error("request accepted while another is in progress");

   // The row read stays put while the final step waits on the receiver.
   a_read_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) && !exec_go |=> $stable(rd_data_ff))
      else $error("bitmap row changed during stall");
`endif

endmodule

`default_nettype wire
